// ===== sv/gn3d_pkg.sv =====
// ---------------------------------------------------------------------------
// gn3d_pkg
// Shared types and constants of the 3-D gradient noise unit.
// ---------------------------------------------------------------------------
package gn3d_pkg;

	// request opcodes
	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_EVAL  = 1'b1
	} op_t;

	localparam int NOISE_W   = 18;
	localparam int NOISE_MAX = 131071;
	localparam int NOISE_MIN = -131072;
	localparam int COORD_W   = 32;
	localparam int ENTRY_W   = 8;
	localparam int HASH_SPAN = 256;

	// table copies: one, two and four at the three lookup levels
	localparam int NCOPY     = 7;

endpackage

// ===== sv/gradient_noise_3d_unit.sv =====
// ---------------------------------------------------------------------------
// gradient_noise_3d_unit
// Improved 3-D gradient noise on signed fixed-point coordinates.
// ---------------------------------------------------------------------------
// Input channel (point_valid / point_stall) carries one request per accept:
// opcode OP_WRITE stores entry_value at entry_index of the permutation
// table and returns nothing; OP_EVAL evaluates the noise at
// (coord_x, coord_y, coord_z) and returns one noise_value on the output
// channel (noise_valid / noise_stall).
// Throughput: one request per cycle while point_stall is low.
// The table lookups run at three levels, each served by its own
// copies of the table (two read ports a copy); a table write walks the same
// pipeline and updates each copy as it passes that level, so requests keep
// their order against table writes.
// Reset: the pipeline empties and a fill pass writes the identity
// permutation into every copy, one entry per cycle, all TABLE_SIZE entries;
// point_stall stays high during the pass.
// When noise_stall is high the output register holds its result; stages
// behind it keep filling bubbles and point_stall rises only when the whole
// pipeline is full.
// ---------------------------------------------------------------------------
module gradient_noise_3d_unit #(
	parameter int TABLE_SIZE = 256,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  logic [0:0]                          opcode,
	input  logic [gn3d_pkg::ENTRY_W-1:0]        entry_index,
	input  logic [gn3d_pkg::ENTRY_W-1:0]        entry_value,
	input  logic signed [gn3d_pkg::COORD_W-1:0] coord_x,
	input  logic signed [gn3d_pkg::COORD_W-1:0] coord_y,
	input  logic signed [gn3d_pkg::COORD_W-1:0] coord_z,
	output logic                                noise_valid,
	input  logic                                noise_stall,
	output logic signed [gn3d_pkg::NOISE_W-1:0] noise_value
);

	localparam int NS    = 13;
	localparam int IW    = $clog2(TABLE_SIZE);
	localparam int FB    = FRAC_BITS;
	localparam int IB    = gn3d_pkg::COORD_W - FB;
	localparam int NW    = ((IB > IW) ? IB : IW) + 1;
	localparam int RW    = NW + 1;
	localparam int OFFS  = TABLE_SIZE * ((2 ** (IB - 1) + TABLE_SIZE - 1) / TABLE_SIZE);
	localparam int RECIP = (2 ** NW) / TABLE_SIZE;
	localparam int W     = FB + 6;
	localparam int EW    = gn3d_pkg::ENTRY_W;

	localparam logic [W-1:0]   ONE_W     = W'(2 ** FB);
	localparam logic [W-1:0]   C15_W     = W'(15 * (2 ** FB));
	localparam logic [2*W-1:0] HALF_W    = (2*W)'(2 ** (FB - 1));
	localparam logic [2*W-1:0] INNER_ADD = ((2*W)'(10) << (2 * FB)) + HALF_W;
	localparam logic [IW:0]    TS_E      = (IW+1)'(TABLE_SIZE);
	localparam logic [IW-1:0]  TLAST     = IW'(TABLE_SIZE - 1);

	// rounded fixed-point product plus a constant, floor after the add
	function automatic logic [W-1:0] fxr(logic [W-1:0] a, logic [W-1:0] b,
			logic [2*W-1:0] addc);
		logic signed [2*W-1:0] p;
		p = $signed(a) * $signed(b) + $signed(addc);
		return p[FB+W-1:FB];
	endfunction

	function automatic logic [IW-1:0] addmod(logic [IW-1:0] p, logic [IW-1:0] c);
		logic [IW:0] s;
		s = {1'b0, p} + {1'b0, c};
		return (s >= TS_E) ? IW'(s - TS_E) : s[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] incmod(logic [IW-1:0] a);
		return (a == TLAST) ? '0 : a + 1'b1;
	endfunction

	// cell index and its successor from a remainder below twice the table size
	function automatic logic [IW-1:0] fold(logic [IW:0] r);
		return (r >= TS_E) ? IW'(r - TS_E) : r[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] fold_inc(logic [IW:0] r);
		logic [IW+1:0] rp;
		rp = {1'b0, r} + 1'b1;
		if (rp == (IW+2)'(TABLE_SIZE) || rp == (IW+2)'(2 * TABLE_SIZE))
			return '0;
		else if (rp > (IW+2)'(TABLE_SIZE))
			return IW'(rp - (IW+2)'(TABLE_SIZE));
		else
			return rp[IW-1:0];
	endfunction

	function automatic logic [W-1:0] grad(logic [3:0] h, logic [W-1:0] x,
			logic [W-1:0] y, logic [W-1:0] z);
		logic [W-1:0] u;
		logic [W-1:0] v;
		u = (h < 4'd8) ? x : y;
		v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	// stage control
	logic [NS:1] valid_q;
	logic [NS:1] ld;
	logic        accept;
	logic        init_q;
	logic [IW-1:0] icnt_q;

	always_comb begin
		ld[NS] = !valid_q[NS] || !noise_stall;
		for (int k = NS - 1; k >= 1; k--)
			ld[k] = !valid_q[k] || ld[k+1];
	end

	assign point_stall = init_q || !ld[1];
	assign accept      = point_valid && !point_stall;
	assign noise_valid = valid_q[NS];

	// residue of a table value modulo the table size
	logic [IW-1:0] mod_lut [gn3d_pkg::HASH_SPAN];
	for (genvar gi = 0; gi < gn3d_pkg::HASH_SPAN; gi++) begin : g_lut
		assign mod_lut[gi] = IW'(gi % TABLE_SIZE);
	end

	// pipeline registers
	gn3d_pkg::op_t op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7, op_s8;
	logic [IW-1:0] wi_s1, wi_s2, wi_s3, wi_s4, wi_s5, wi_s6, wi_s7, wi_s8;
	logic [EW-1:0] wd_s1, wd_s2, wd_s3, wd_s4, wd_s5, wd_s6, wd_s7, wd_s8;
	logic [2:0][FB-1:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7, t_s8, t_s9;
	logic [2:0][W-1:0]  f_s2, f_s3, f_s4, f_s5, f_s6, f_s7, f_s8, f_s9, f_s10,
		f_s11, f_s12;
	logic [2:0][NW-1:0] n_s1, n_s2;
	logic [2:0][RW-1:0] q_s2;
	logic [2:0][IW:0]   r_s3;
	logic [2:0][IW-1:0] c_s4;
	logic [IW-1:0] cx1_s4;
	logic [IW-1:0] cy_s5, cz_s5, cz_s6, cz_s7;
	logic [IW-1:0] a_s6, a1_s6, b_s6, b1_s6;
	logic [7:0][IW-1:0] h_s8;
	logic [7:0][W-1:0]  g_s10;
	logic [3:0][W-1:0]  l_s11;
	logic [1:0][W-1:0]  m_s12;
	logic signed [gn3d_pkg::NOISE_W-1:0] noise_s13;

	// table copies
	logic          mwe  [gn3d_pkg::NCOPY];
	logic          mre  [gn3d_pkg::NCOPY];
	logic [IW-1:0] mwa  [gn3d_pkg::NCOPY];
	logic [EW-1:0] mwd  [gn3d_pkg::NCOPY];
	logic [IW-1:0] mra0 [gn3d_pkg::NCOPY];
	logic [IW-1:0] mra1 [gn3d_pkg::NCOPY];
	logic [EW-1:0] mrd0 [gn3d_pkg::NCOPY];
	logic [EW-1:0] mrd1 [gn3d_pkg::NCOPY];

	always_comb begin
		for (int c = 0; c < gn3d_pkg::NCOPY; c++) begin
			if (c == 0) begin
				mwe[c]  = init_q || (valid_q[4] && op_s4 == gn3d_pkg::OP_WRITE && ld[5]);
				mwa[c]  = init_q ? icnt_q : wi_s4;
				mwd[c]  = init_q ? EW'(icnt_q) : wd_s4;
				mre[c]  = ld[5];
				mra0[c] = c_s4[0];
				mra1[c] = cx1_s4;
			end else if (c < 3) begin
				mwe[c]  = init_q || (valid_q[6] && op_s6 == gn3d_pkg::OP_WRITE && ld[7]);
				mwa[c]  = init_q ? icnt_q : wi_s6;
				mwd[c]  = init_q ? EW'(icnt_q) : wd_s6;
				mre[c]  = ld[7];
				mra0[c] = (c == 1) ? a_s6 : b_s6;
				mra1[c] = (c == 1) ? a1_s6 : b1_s6;
			end else begin
				mwe[c]  = init_q || (valid_q[8] && op_s8 == gn3d_pkg::OP_WRITE && ld[9]);
				mwa[c]  = init_q ? icnt_q : wi_s8;
				mwd[c]  = init_q ? EW'(icnt_q) : wd_s8;
				mre[c]  = ld[9];
				mra0[c] = h_s8[2*(c-3)];
				mra1[c] = h_s8[2*(c-3)+1];
			end
		end
	end

	for (genvar gc = 0; gc < gn3d_pkg::NCOPY; gc++) begin : g_copy
		logic [EW-1:0] mem [TABLE_SIZE];
		always_ff @(posedge clk) begin
			if (mwe[gc])
				mem[mwa[gc]] <= mwd[gc];
			if (mre[gc]) begin
				mrd0[gc] <= mem[mra0[gc]];
				mrd1[gc] <= mem[mra1[gc]];
			end
		end
	end

	// fill pass and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= 1'b1;
			icnt_q  <= '0;
			valid_q <= '0;
		end else begin
			if (init_q) begin
				icnt_q <= icnt_q + 1'b1;
				if (icnt_q == TLAST)
					init_q <= 1'b0;
			end
			if (ld[1])
				valid_q[1] <= accept;
			for (int k = 2; k <= NS; k++) begin
				if (ld[k]) begin
					if (k == 9)
						valid_q[k] <= valid_q[8] && op_s8 == gn3d_pkg::OP_EVAL;
					else
						valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	// s1: split coordinates into offset cell and fraction
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			op_s1 <= gn3d_pkg::op_t'(opcode);
			wi_s1 <= mod_lut[entry_index];
			wd_s1 <= entry_value;
			t_s1[0] <= coord_x[FB-1:0];
			t_s1[1] <= coord_y[FB-1:0];
			t_s1[2] <= coord_z[FB-1:0];
			n_s1[0] <= {{(NW-IB){coord_x[31]}}, coord_x[31:FB]} + NW'(OFFS);
			n_s1[1] <= {{(NW-IB){coord_y[31]}}, coord_y[31:FB]} + NW'(OFFS);
			n_s1[2] <= {{(NW-IB){coord_z[31]}}, coord_z[31:FB]} + NW'(OFFS);
		end
	end

	// s2..s5: cell modulo table size; fade polynomial
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			op_s2 <= op_s1; wi_s2 <= wi_s1; wd_s2 <= wd_s1; t_s2 <= t_s1; n_s2 <= n_s1;
			for (int i = 0; i < 3; i++) begin
				q_s2[i] <= RW'(((NW+RW)'(n_s1[i]) * (NW+RW)'(RECIP)) >> NW);
				f_s2[i] <= fxr(W'(t_s1[i]),
					W'({t_s1[i], 2'b00}) + W'({t_s1[i], 1'b0}) - C15_W, INNER_ADD);
			end
		end
		if (ld[3]) begin
			op_s3 <= op_s2; wi_s3 <= wi_s2; wd_s3 <= wd_s2; t_s3 <= t_s2;
			for (int i = 0; i < 3; i++) begin
				r_s3[i] <= (IW+1)'(n_s2[i]
					- NW'((NW+RW)'(q_s2[i]) * (NW+RW)'(TABLE_SIZE)));
				f_s3[i] <= fxr(W'(t_s2[i]), f_s2[i], HALF_W);
			end
		end
		if (ld[4]) begin
			op_s4 <= op_s3; wi_s4 <= wi_s3; wd_s4 <= wd_s3; t_s4 <= t_s3;
			cx1_s4 <= fold_inc(r_s3[0]);
			for (int i = 0; i < 3; i++) begin
				c_s4[i] <= fold(r_s3[i]);
				f_s4[i] <= fxr(W'(t_s3[i]), f_s3[i], HALF_W);
			end
		end
		if (ld[5]) begin
			op_s5 <= op_s4; wi_s5 <= wi_s4; wd_s5 <= wd_s4; t_s5 <= t_s4;
			cy_s5 <= c_s4[1];
			cz_s5 <= c_s4[2];
			for (int i = 0; i < 3; i++)
				f_s5[i] <= fxr(W'(t_s4[i]), f_s4[i], HALF_W);
		end
	end

	// s6..s9: corner hashing through the table copies
	always_ff @(posedge clk) begin
		if (ld[6]) begin
			op_s6 <= op_s5; wi_s6 <= wi_s5; wd_s6 <= wd_s5; t_s6 <= t_s5; f_s6 <= f_s5;
			cz_s6 <= cz_s5;
			a_s6  <= addmod(mod_lut[mrd0[0]], cy_s5);
			a1_s6 <= incmod(addmod(mod_lut[mrd0[0]], cy_s5));
			b_s6  <= addmod(mod_lut[mrd1[0]], cy_s5);
			b1_s6 <= incmod(addmod(mod_lut[mrd1[0]], cy_s5));
		end
		if (ld[7]) begin
			op_s7 <= op_s6; wi_s7 <= wi_s6; wd_s7 <= wd_s6; t_s7 <= t_s6; f_s7 <= f_s6;
			cz_s7 <= cz_s6;
		end
		if (ld[8]) begin
			op_s8 <= op_s7; wi_s8 <= wi_s7; wd_s8 <= wd_s7; t_s8 <= t_s7; f_s8 <= f_s7;
			// order: aa, aa+1, ab, ab+1, ba, ba+1, bb, bb+1
			h_s8[0] <= addmod(mod_lut[mrd0[1]], cz_s7);
			h_s8[1] <= incmod(addmod(mod_lut[mrd0[1]], cz_s7));
			h_s8[2] <= addmod(mod_lut[mrd1[1]], cz_s7);
			h_s8[3] <= incmod(addmod(mod_lut[mrd1[1]], cz_s7));
			h_s8[4] <= addmod(mod_lut[mrd0[2]], cz_s7);
			h_s8[5] <= incmod(addmod(mod_lut[mrd0[2]], cz_s7));
			h_s8[6] <= addmod(mod_lut[mrd1[2]], cz_s7);
			h_s8[7] <= incmod(addmod(mod_lut[mrd1[2]], cz_s7));
		end
		if (ld[9]) begin
			t_s9 <= t_s8;
			f_s9 <= f_s8;
		end
	end

	// s10: gradient dot products; s11..s13: trilinear blend and clamp
	logic [W-1:0] x0, y0, z0, x1, y1, z1;
	logic [W-1:0] r_mix;
	int           r_int;

	always_comb begin
		x0 = W'(t_s9[0]);
		y0 = W'(t_s9[1]);
		z0 = W'(t_s9[2]);
		x1 = x0 - ONE_W;
		y1 = y0 - ONE_W;
		z1 = z0 - ONE_W;
		r_mix = m_s12[0] + fxr(f_s12[2], m_s12[1] - m_s12[0], HALF_W);
		r_int = int'($signed(r_mix));
	end

	always_ff @(posedge clk) begin
		if (ld[10]) begin
			f_s10 <= f_s9;
			g_s10[0] <= grad(mrd0[3][3:0], x0, y0, z0);
			g_s10[1] <= grad(mrd0[5][3:0], x1, y0, z0);
			g_s10[2] <= grad(mrd0[4][3:0], x0, y1, z0);
			g_s10[3] <= grad(mrd0[6][3:0], x1, y1, z0);
			g_s10[4] <= grad(mrd1[3][3:0], x0, y0, z1);
			g_s10[5] <= grad(mrd1[5][3:0], x1, y0, z1);
			g_s10[6] <= grad(mrd1[4][3:0], x0, y1, z1);
			g_s10[7] <= grad(mrd1[6][3:0], x1, y1, z1);
		end
		if (ld[11]) begin
			f_s11 <= f_s10;
			for (int i = 0; i < 4; i++)
				l_s11[i] <= g_s10[2*i]
					+ fxr(f_s10[0], g_s10[2*i+1] - g_s10[2*i], HALF_W);
		end
		if (ld[12]) begin
			f_s12 <= f_s11;
			for (int i = 0; i < 2; i++)
				m_s12[i] <= l_s11[2*i]
					+ fxr(f_s11[1], l_s11[2*i+1] - l_s11[2*i], HALF_W);
		end
		if (ld[13]) begin
			if (r_int > gn3d_pkg::NOISE_MAX)
				noise_s13 <= gn3d_pkg::NOISE_W'(gn3d_pkg::NOISE_MAX);
			else if (r_int < gn3d_pkg::NOISE_MIN)
				noise_s13 <= gn3d_pkg::NOISE_W'(gn3d_pkg::NOISE_MIN);
			else
				noise_s13 <= gn3d_pkg::NOISE_W'(r_int);
		end
	end

	assign noise_value = noise_s13;

endmodule

// ===== tb/tb_gradient_noise_3d_unit.sv =====
// ---------------------------------------------------------------------------
// tb_gradient_noise_3d_unit
// Self-checking bench for the 3-D gradient noise unit: table writes and point
// evaluations, directed corners first, then random traffic with random gaps
// and output stalls; each noise result is checked against a local model or a typed value.
// ---------------------------------------------------------------------------
module tb_gradient_noise_3d_unit;

	localparam int NUM_RANDOM = 1369;
	localparam int FB         = 16;
	localparam longint ONE    = 64'sd1 << FB;

	logic                                clk;
	logic                                arst_n;
	logic                                point_valid;
	logic                                point_stall;
	logic [0:0]                          opcode;
	logic [gn3d_pkg::ENTRY_W-1:0]        entry_index;
	logic [gn3d_pkg::ENTRY_W-1:0]        entry_value;
	logic signed [gn3d_pkg::COORD_W-1:0] coord_x;
	logic signed [gn3d_pkg::COORD_W-1:0] coord_y;
	logic signed [gn3d_pkg::COORD_W-1:0] coord_z;
	logic                                noise_valid;
	logic                                noise_stall;
	logic signed [gn3d_pkg::NOISE_W-1:0] noise_value;

	gradient_noise_3d_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall),
		.opcode(opcode), .entry_index(entry_index), .entry_value(entry_value),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.noise_valid(noise_valid), .noise_stall(noise_stall),
		.noise_value(noise_value)
	);

	typedef struct {
		gn3d_pkg::op_t                       op;
		logic [7:0]                          idx;
		logic [7:0]                          val;
		logic signed [31:0]                  x;
		logic signed [31:0]                  y;
		logic signed [31:0]                  z;
		bit                                  has_fixed;
		logic signed [gn3d_pkg::NOISE_W-1:0] fixed_noise;
	} request_t;

	logic [7:0]                          perm_shadow [256];
	logic signed [gn3d_pkg::NOISE_W-1:0] noise_queue [$];
	int  mismatches;
	int  evals_sent;
	int  noise_seen;
	int  writes_sent;
	bit  done_driving;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint round_mul(longint a, longint b);
		longint p;
		p = a * b + (ONE >>> 1);
		return p >>> FB;
	endfunction

	function automatic longint fade_q(longint t);
		longint inner;
		inner = round_mul(t, 6 * t - 15 * ONE) + 10 * ONE;
		return round_mul(t, round_mul(t, round_mul(t, inner)));
	endfunction

	function automatic longint blend(longint t, longint a, longint b);
		return a + round_mul(t, b - a);
	endfunction

	function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
		logic [3:0] h;
		longint u, v;
		h = hash[3:0];
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic logic [7:0] perm_at(int i);
		return perm_shadow[8'(i)];
	endfunction

	// cell is floor(c) mod 256 = bits [23:16]; fraction = low 16 bits
	function automatic logic signed [gn3d_pkg::NOISE_W-1:0] noise_at(
			logic signed [31:0] cx, logic signed [31:0] cy, logic signed [31:0] cz);
		int ix, iy, iz, a, aa, ab, b, ba, bb;
		longint x, y, z, x1, y1, z1, u, v, w, r;
		ix = int'(cx[23:16]); iy = int'(cy[23:16]); iz = int'(cz[23:16]);
		x = longint'(cx[15:0]); y = longint'(cy[15:0]); z = longint'(cz[15:0]);
		u = fade_q(x); v = fade_q(y); w = fade_q(z);
		x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
		a  = (perm_at(ix) + iy) & 255;
		aa = (perm_at(a) + iz) & 255;
		ab = (perm_at(a + 1) + iz) & 255;
		b  = (perm_at(ix + 1) + iy) & 255;
		ba = (perm_at(b) + iz) & 255;
		bb = (perm_at(b + 1) + iz) & 255;
		r = blend(w,
			blend(v,
				blend(u, corner_dot(perm_at(aa), x, y, z), corner_dot(perm_at(ba), x1, y, z)),
				blend(u, corner_dot(perm_at(ab), x, y1, z), corner_dot(perm_at(bb), x1, y1, z))),
			blend(v,
				blend(u, corner_dot(perm_at(aa + 1), x, y, z1),
					corner_dot(perm_at(ba + 1), x1, y, z1)),
				blend(u, corner_dot(perm_at(ab + 1), x, y1, z1),
					corner_dot(perm_at(bb + 1), x1, y1, z1))));
		if (r > longint'(gn3d_pkg::NOISE_MAX)) r = longint'(gn3d_pkg::NOISE_MAX);
		if (r < longint'(gn3d_pkg::NOISE_MIN)) r = longint'(gn3d_pkg::NOISE_MIN);
		return r[gn3d_pkg::NOISE_W-1:0];
	endfunction

	function automatic request_t eval_req(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		request_t q;
		q = '{gn3d_pkg::OP_EVAL, 8'($urandom), 8'($urandom), x, y, z, 1'b0, '0};
		return q;
	endfunction

	function automatic request_t write_req(logic [7:0] i, logic [7:0] v);
		request_t q;
		q = '{gn3d_pkg::OP_WRITE, i, v, $urandom, $urandom, $urandom, 1'b0, '0};
		return q;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {8'd0, 8'($urandom_range(0, 255)), 16'($urandom)};
			2: return -$signed({8'd0, 8'($urandom), 16'($urandom)});
			3: return {16'($urandom), 16'hffff};
			4: return {16'($urandom), 16'h0000};
			default: return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
		endcase
	endfunction

	// predict on accept, in order against table writes
	task automatic send(request_t q);
		point_valid <= 1'b1;
		opcode      <= q.op;
		entry_index <= q.idx;
		entry_value <= q.val;
		coord_x     <= q.x;
		coord_y     <= q.y;
		coord_z     <= q.z;
		@(posedge clk);
		while (point_stall) @(posedge clk);
		if (q.op == gn3d_pkg::OP_WRITE) begin
			perm_shadow[q.idx] = q.val;
			writes_sent++;
		end else begin
			logic signed [gn3d_pkg::NOISE_W-1:0] e;
			e = noise_at(q.x, q.y, q.z);
			if (q.has_fixed && e != q.fixed_noise)
				$display("note: typed value %0d differs from prediction %0d", q.fixed_noise, e);
			noise_queue.push_back(q.has_fixed ? q.fixed_noise : e);
			evals_sent++;
		end
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			point_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// output side: random stalls; check on accept
	always @(posedge clk) begin
		if (arst_n && noise_valid && !noise_stall) begin
			noise_seen++;
			if (noise_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected noise result %0d", noise_value);
			end else begin
				logic signed [gn3d_pkg::NOISE_W-1:0] want;
				want = noise_queue.pop_front();
				if (want !== noise_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("noise mismatch: expected %0d got %0d", want, noise_value);
				end
			end
		end
	end

	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_stall <= 1'b0;
			stall_left  = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			noise_stall <= 1'b1;
		end else if (done_driving || $urandom_range(0, 9) < 6) begin
			noise_stall <= 1'b0;
		end else begin
			stall_left = gap_len();
			noise_stall <= (stall_left > 0);
		end
	end

	initial begin
		#40000000;
		$display("timeout with %0d results outstanding", noise_queue.size());
		$display("** gradient_noise_3d_unit: FAILED **");
		$finish;
	end

	initial begin
		request_t directed [$];
		int wait_cycles;
		for (int i = 0; i < 256; i++) perm_shadow[i] = 8'(i);
		mismatches = 0; evals_sent = 0; noise_seen = 0; writes_sent = 0;
		done_driving = 1'b0;
		arst_n = 1'b0;
		point_valid = 1'b0; opcode = gn3d_pkg::OP_WRITE; entry_index = '0; entry_value = '0;
		coord_x = '0; coord_y = '0; coord_z = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// integer lattice points give zero noise (all offsets zero at corner 0)
		directed.push_back(eval_req(32'sh0, 32'sh0, 32'sh0));
		directed[$].has_fixed = 1'b1; directed[$].fixed_noise = '0;
		directed.push_back(eval_req(32'sh0005_0000, -32'sh0003_0000, 32'sh00ff_0000));
		directed[$].has_fixed = 1'b1; directed[$].fixed_noise = '0;
		directed.push_back(eval_req(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
		directed.push_back(eval_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		directed.push_back(eval_req(-32'sh1, -32'sh1, -32'sh1));
		directed.push_back(eval_req(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000));
		directed.push_back(eval_req(32'sh0000_ffff, 32'sh0000_0001, -32'sh0000_8000));
		directed.push_back(eval_req(32'sh00ff_ffff, 32'shff00_0000, 32'sh0100_4000));
		// non-permutation table contents and writes at the index extremes
		directed.push_back(write_req(8'd0, 8'd255));
		directed.push_back(write_req(8'd255, 8'd0));
		directed.push_back(write_req(8'd1, 8'd255));
		directed.push_back(eval_req(32'sh0000_4000, 32'sh0000_c000, 32'sh0000_2000));
		directed.push_back(eval_req(32'sh00ff_a000, 32'sh00ff_6000, 32'sh00ff_e000));
		for (int h = 0; h < 16; h += 3) begin
			directed.push_back(write_req(8'd7, 8'(h | 8'hf0)));
			directed.push_back(eval_req(32'sh0007_3456, 32'sh0000_789a, 32'sh0000_bcde));
		end
		foreach (directed[i]) send(directed[i]);

		for (int n = 0; n < NUM_RANDOM; n++) begin
			if ($urandom_range(0, 9) < 2)
				send(write_req(8'($urandom), 8'($urandom)));
			else
				send(eval_req(rand_coord(), rand_coord(), rand_coord()));
			if (n == NUM_RANDOM / 2) begin
				// restore identity midway so stock behavior is exercised
				for (int i = 0; i < 256; i++) send(write_req(8'(i), 8'(i)));
			end
			if (n % 400 < 300) pause(gap_len());
		end
		point_valid <= 1'b0;
		done_driving = 1'b1;

		wait_cycles = 0;
		while (noise_queue.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (30) @(posedge clk);
		$display("sent %0d table writes and %0d evaluations; %0d results checked",
			writes_sent, evals_sent, noise_seen);
		if (mismatches == 0 && noise_queue.size() == 0)
			$display("** gradient_noise_3d_unit: PASSED **");
		else
			$display("** gradient_noise_3d_unit: FAILED **");
		$finish;
	end

endmodule
